>>> rtl/core/ncs_pkg.sv
// Shared constants, register codes and control types of the nearest-centroid search.
package ncs_pkg;

  // Fixed field widths of the streaming items
  localparam int NUM_COORDS = 8;
  localparam int FIELD_W    = 16;
  localparam int INDEX_W    = 8;
  localparam int DIST_W     = 35;
  localparam int CCOUNT_W   = 9;
  localparam int DCOUNT_W   = 4;
  localparam int S_TDATA_W  = 136;
  localparam int M_TDATA_W  = 48;

  // Defaults of the top-level parameters
  localparam int DEF_MAX_CENTROIDS = 256;
  localparam int DEF_MAX_DIMS      = 8;
  localparam int DEF_COORD_BITS    = 16;

  // Register indexes, taken from address bit 2
  localparam logic REG_CENTROID_COUNT  = 1'b0;
  localparam logic REG_DIMENSION_COUNT = 1'b1;

  // Item kinds carried on tuser
  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic write;
    logic issue;
    logic load_out;
  } ncs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_last;
    logic pipe_empty;
    logic out_free;
  } ncs_status_t;

endpackage

>>> rtl/core/nearest_centroid_search_top.sv
// A classify walks N store rows (one store row read per cycle), N being the clamped centroid
// count, then drains the distance pipeline before its result is loaded into the output register.
// One item at a time: s_tready is low from a classify until its result is loaded, and a
// classify cannot finish while an earlier result waits and m_tready is low.
// Reset clears the controller, the pipeline valids and both registers (count 1, dims 8);
// the centroid store is not cleared and is undefined until written.
module nearest_centroid_search_top
  import ncs_pkg::*;
#(
  parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
  parameter int MAX_DIMS      = DEF_MAX_DIMS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: centroid_index[7:0], coord0[23:8], coord1[39:24], coord2[55:40],
  // coord3[71:56], coord4[87:72], coord5[103:88], coord6[119:104], coord7[135:120]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: func[0]
  input  logic                 s_tuser,
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: best_index[7:0], best_distance[42:8], zeros[47:43]
  output logic [M_TDATA_W-1:0] m_tdata,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [CCOUNT_W-1:0]               centroid_count;
  logic [DCOUNT_W-1:0]               dimension_count;
  logic [NUM_COORDS-1:0][FIELD_W-1:0] coords;
  logic [INDEX_W-1:0]                best_index;
  logic [DIST_W-1:0]                 best_distance;
  ncs_cmd_t                          cmd;
  ncs_status_t                       status;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_count  <= CCOUNT_W'(1);
      dimension_count <= DCOUNT_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_CENTROID_COUNT:  centroid_count  <= pwdata[CCOUNT_W-1:0];
        REG_DIMENSION_COUNT: dimension_count <= pwdata[DCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CENTROID_COUNT:  prdata = 32'(centroid_count);
      REG_DIMENSION_COUNT: prdata = 32'(dimension_count);
      default:             prdata = '0;
    endcase
  end

  // Unpack the coordinates of an input transfer
  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      coords[k] = s_tdata[INDEX_W + k*FIELD_W +: FIELD_W];
    end
  end

  ncs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ncs_datapath #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .MAX_DIMS      (MAX_DIMS),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .centroid_count  (centroid_count),
    .dimension_count (dimension_count),
    .centroid_index  (s_tdata[INDEX_W-1:0]),
    .coords          (coords),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_index       (best_index),
    .out_distance    (best_distance)
  );

  // Pack the result transfer
  assign m_tdata = {(M_TDATA_W - INDEX_W - DIST_W)'(0), best_distance, best_index};

endmodule

>>> rtl/core/ncs_ctrl.sv
// Controller state machine that sequences centroid writes and the classify walk.
module ncs_ctrl
  import ncs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_ready,
  input  ncs_status_t status,
  output ncs_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_CLASSIFY) begin
            cmd.start  = 1'b1;
            state_next = S_WALK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (status.at_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.pipe_empty && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/ncs_datapath.sv
// Centroid store, distance pipeline, running minimum and output register.
module ncs_datapath
  import ncs_pkg::*;
#(
  parameter int MAX_CENTROIDS = DEF_MAX_CENTROIDS,
  parameter int MAX_DIMS      = DEF_MAX_DIMS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ncs_cmd_t                            cmd,
  output ncs_status_t                         status,
  input  logic [CCOUNT_W-1:0]                 centroid_count,
  input  logic [DCOUNT_W-1:0]                 dimension_count,
  input  logic [INDEX_W-1:0]                  centroid_index,
  input  logic [NUM_COORDS-1:0][FIELD_W-1:0]  coords,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [INDEX_W-1:0]                  out_index,
  output logic [DIST_W-1:0]                   out_distance
);

  localparam int ADDR_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CW     = (ADDR_W + 1 > CCOUNT_W) ? ADDR_W + 1 : CCOUNT_W;
  localparam int ROW_W  = MAX_DIMS * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int PAIR_W = SQ_W + 1;
  localparam int SUM_W  = SQ_W + 3;
  localparam int PAIRS  = NUM_COORDS / 2;

  // Centroid store: one row of all dimensions per entry
  logic [ROW_W-1:0] mem [MAX_CENTROIDS];
  logic [ROW_W-1:0] rd_data;

  logic [COORD_BITS-1:0] pt [MAX_DIMS];
  logic [MAX_DIMS-1:0]   lane_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     last_addr;

  logic              v0, v1, v2, v3;
  logic [ADDR_W-1:0] idx0, idx1, idx2, idx3;
  logic [SQ_W-1:0]   sq_c [NUM_COORDS];
  logic [SQ_W-1:0]   sq1  [NUM_COORDS];
  logic [PAIR_W-1:0] pair [PAIRS];
  logic [SUM_W-1:0]  total;

  logic              first;
  logic [SUM_W-1:0]  best;
  logic [ADDR_W-1:0] best_idx;

  logic [CW-1:0]       cnt_ext;
  logic [CW-1:0]       cnt_eff;
  logic [DCOUNT_W-1:0] dims_eff;
  logic [ROW_W-1:0]    wr_row;
  logic                wr_in_range;

  // Clamp the register counts to the supported ranges
  always_comb begin
    cnt_ext = CW'(centroid_count);
    if (cnt_ext == '0) begin
      cnt_eff = CW'(1);
    end else if (cnt_ext > CW'(MAX_CENTROIDS)) begin
      cnt_eff = CW'(MAX_CENTROIDS);
    end else begin
      cnt_eff = cnt_ext;
    end
    if (dimension_count == '0) begin
      dims_eff = DCOUNT_W'(1);
    end else if (dimension_count > DCOUNT_W'(MAX_DIMS)) begin
      dims_eff = DCOUNT_W'(MAX_DIMS);
    end else begin
      dims_eff = dimension_count;
    end
  end

  // Row to store and range check of the write index
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      wr_row[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(coords[k]);
    end
    wr_in_range = (32'(centroid_index) < 32'(MAX_CENTROIDS));
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write && wr_in_range) begin
      mem[ADDR_W'(centroid_index)] <= wr_row;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Point, lane enables and walk counter, latched when a classify starts
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        pt[k]      <= COORD_BITS'(coords[k]);
        lane_en[k] <= (DCOUNT_W'(k) < dims_eff);
      end
      last_addr <= ADDR_W'(cnt_eff - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (cmd.start) begin
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
  end

  // Squared difference per lane, zero for unused lanes
  for (genvar g = 0; g < NUM_COORDS; g++) begin : g_lane
    if (g < MAX_DIMS) begin : g_used
      logic signed [COORD_BITS:0]     diff;
      logic signed [2*COORD_BITS+1:0] prod;
      logic [COORD_BITS-1:0]          cval;
      assign cval    = rd_data[g*COORD_BITS +: COORD_BITS];
      assign diff    = $signed({pt[g][COORD_BITS-1], pt[g]})
                     - $signed({cval[COORD_BITS-1], cval});
      assign prod    = diff * diff;
      assign sq_c[g] = lane_en[g] ? SQ_W'(prod) : '0;
    end else begin : g_pad
      assign sq_c[g] = '0;
    end
  end

  // Distance pipeline: squares, pair sums, total
  always_ff @(posedge clk) begin
    sq1  <= sq_c;
    idx0 <= rd_addr;
    idx1 <= idx0;
    idx2 <= idx1;
    idx3 <= idx2;
    for (int p = 0; p < PAIRS; p++) begin
      pair[p] <= PAIR_W'(sq1[2*p]) + PAIR_W'(sq1[2*p+1]);
    end
    total <= (SUM_W'(pair[0]) + SUM_W'(pair[1])) + (SUM_W'(pair[2]) + SUM_W'(pair[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Running minimum; only a strictly smaller sum replaces the best
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (cmd.start) begin
      first <= 1'b1;
    end else if (v3) begin
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (first || total < best)) begin
      best     <= total;
      best_idx <= idx3;
    end
  end

  // Output register, loaded once the walk has drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_index    <= INDEX_W'(best_idx);
      out_distance <= DIST_W'(best);
    end
  end

  assign status.at_last    = (rd_addr == last_addr);
  assign status.pipe_empty = !(v0 || v1 || v2 || v3);
  assign status.out_free   = !out_valid || out_ready;

endmodule
